// File: design/tls_pkg.sv
// shared types, codes and helpers for the tricolour led sequencer
`timescale 1ns / 1ps
`default_nettype none

package tls_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int PERIOD_W        = 16;
    localparam int APB_ADDR_W      = 4;
    localparam int APB_DATA_W      = 32;

    localparam logic [PERIOD_W-1:0] GLOW_FOREVER = 16'hFFFF;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd500;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_STARTUP = 2'd1;
    localparam logic [1:0] MODE_SHOW    = 2'd2;

    localparam logic [2:0] EV_TICK = 3'd0;
    localparam logic [2:0] EV_RUN  = 3'd1;
    localparam logic [2:0] EV_DONE = 3'd2;
    localparam logic [2:0] EV_SHOW = 3'd3;
    localparam logic [2:0] EV_OFF  = 3'd4;

    localparam logic [1:0] COLOR_RED    = 2'd0;
    localparam logic [1:0] COLOR_YELLOW = 2'd1;
    localparam logic [1:0] COLOR_GREEN  = 2'd2;
    localparam logic [1:0] COLOR_NONE   = 2'd3;

    localparam logic [1:0] REG_CYCLE     = 2'd0;
    localparam logic [1:0] REG_BLINK_ON  = 2'd1;
    localparam logic [1:0] REG_BLINK_OFF = 2'd2;

    typedef struct packed {
        logic [PERIOD_W-1:0] cycle_period;
        logic [PERIOD_W-1:0] blink_on_period;
        logic [PERIOD_W-1:0] blink_off_period;
    } cfg_t;

    typedef struct packed {
        logic       red_on;
        logic       yellow_on;
        logic       green_on;
        logic [1:0] mode;
    } result_t;

    // led pattern for a colour code, bit 0 red, bit 1 yellow, bit 2 green
    function automatic logic [2:0] color_bits(input logic [1:0] c);
        logic [2:0] bits;
        case (c)
            COLOR_RED:    bits = 3'b001;
            COLOR_YELLOW: bits = 3'b010;
            COLOR_GREEN:  bits = 3'b100;
            default:      bits = 3'b000;
        endcase
        return bits;
    endfunction

endpackage

`default_nettype wire

// File: design/tls_ctrl.sv
// controller state and combinational step logic for one event transfer
`timescale 1ns / 1ps
`default_nettype none

module tls_ctrl #(
    parameter int TIMER_WIDTH = tls_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tls_pkg::cfg_t                  cfg,
    input  wire logic                           step_en,
    input  wire logic [2:0]                     req_type,
    input  wire logic [1:0]                     color,
    input  wire logic [tls_pkg::PERIOD_W-1:0]   glow_time,
    input  wire logic                           blink_enable,
    output tls_pkg::result_t                    res
);
    import tls_pkg::*;

    // compare width covers both the timers and the 16-bit periods
    localparam int CW = (TIMER_WIDTH > PERIOD_W) ? TIMER_WIDTH : PERIOD_W;

    logic [1:0]             mode_reg,        mode_next;
    logic [1:0]             step_reg,        step_next;
    logic [TIMER_WIDTH-1:0] main_reg,        main_next;
    logic [TIMER_WIDTH-1:0] blink_reg,       blink_next;
    logic                   phase_on_reg,    phase_on_next;
    logic [1:0]             sh_color_reg,    sh_color_next;
    logic [PERIOD_W-1:0]    sh_glow_reg,     sh_glow_next;
    logic                   sh_blink_reg,    sh_blink_next;
    logic [2:0]             led_reg,         led_next;

    logic [TIMER_WIDTH-1:0] main_t;
    logic [TIMER_WIDTH-1:0] blink_t;
    logic                   tick;
    logic                   expired;

    assign tick = (req_type == EV_TICK);

    always_comb
    begin
        // timers saturate at all ones
        main_t  = main_reg;
        blink_t = blink_reg;
        if (tick)
        begin
            if (main_reg != '1)
                main_t = main_reg + TIMER_WIDTH'(1);
            if (blink_reg != '1)
                blink_t = blink_reg + TIMER_WIDTH'(1);
        end

        mode_next     = mode_reg;
        step_next     = step_reg;
        main_next     = main_t;
        blink_next    = blink_t;
        phase_on_next = phase_on_reg;
        sh_color_next = sh_color_reg;
        sh_glow_next  = sh_glow_reg;
        sh_blink_next = sh_blink_reg;
        led_next      = led_reg;

        expired = (sh_glow_reg != GLOW_FOREVER) && (CW'(main_t) >= CW'(sh_glow_reg));

        case (mode_reg)
            MODE_STARTUP:
            begin
                if (req_type == EV_DONE)
                begin
                    mode_next = MODE_IDLE;
                    led_next  = 3'b000;
                end
                else if (CW'(main_t) >= CW'(cfg.cycle_period))
                begin
                    // red, yellow, green, then back to red
                    step_next = (step_reg == 2'd3) ? 2'd1 : step_reg + 2'd1;
                    led_next  = color_bits(step_next - 2'd1);
                    main_next = '0;
                end
            end
            MODE_IDLE:
            begin
                if (req_type == EV_RUN)
                begin
                    mode_next = MODE_STARTUP;
                    main_next = '0;
                end
                else if (req_type == EV_SHOW)
                begin
                    sh_color_next = color;
                    sh_glow_next  = glow_time;
                    sh_blink_next = blink_enable;
                    phase_on_next = 1'b1;
                    mode_next     = MODE_SHOW;
                    main_next     = '0;
                    blink_next    = '0;
                end
            end
            MODE_SHOW:
            begin
                if (expired || (req_type == EV_OFF))
                begin
                    led_next  = 3'b000;
                    mode_next = MODE_IDLE;
                end
                else if (phase_on_reg)
                begin
                    // colour none keeps the leds as they are
                    if (sh_color_reg != COLOR_NONE)
                        led_next = color_bits(sh_color_reg);
                    if (sh_blink_reg && (CW'(blink_t) >= CW'(cfg.blink_on_period)))
                    begin
                        phase_on_next = 1'b0;
                        blink_next    = '0;
                    end
                end
                else
                begin
                    led_next = 3'b000;
                    if (sh_blink_reg && (CW'(blink_t) >= CW'(cfg.blink_off_period)))
                    begin
                        phase_on_next = 1'b1;
                        blink_next    = '0;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            step_reg     <= 2'd0;
            main_reg     <= '0;
            blink_reg    <= '0;
            phase_on_reg <= 1'b0;
            sh_color_reg <= 2'd0;
            sh_glow_reg  <= '0;
            sh_blink_reg <= 1'b0;
            led_reg      <= 3'b000;
        end
        else if (step_en)
        begin
            mode_reg     <= mode_next;
            step_reg     <= step_next;
            main_reg     <= main_next;
            blink_reg    <= blink_next;
            phase_on_reg <= phase_on_next;
            sh_color_reg <= sh_color_next;
            sh_glow_reg  <= sh_glow_next;
            sh_blink_reg <= sh_blink_next;
            led_reg      <= led_next;
        end
    end

    assign res.red_on    = led_next[0];
    assign res.yellow_on = led_next[1];
    assign res.green_on  = led_next[2];
    assign res.mode      = mode_next;

endmodule

`default_nettype wire

// File: design/tricolor_led_sequencer.sv
// top level of the tricolour led sequencer: register port, controller, result queue
`timescale 1ns / 1ps
`default_nettype none

// Three-LED (red, yellow, green) sequencer driven by one event per item transfer.
// Every accepted item produces exactly one result: the LED levels and the mode
// after the controller's step. The step is done in the cycle the item is
// accepted, so an item can be taken on every clock; the result lands in a
// two-entry queue, so new items keep flowing while the oldest result waits for
// result_ready, and item_ready only drops when both entries are full. The
// result_valid flag rises in the cycle after the item transfer. Periods are
// written through the APB-style port at 0x0 (cycle), 0x4 (blink on) and 0x8
// (blink off), all 16 bits, reset to 500; writes take effect on the next item.

module tricolor_led_sequencer #(
    parameter int TIMER_WIDTH = tls_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    // apb-style register port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tls_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [tls_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [tls_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,

    // event items
    input  wire logic                             item_valid,
    output logic                                  item_ready,
    input  wire logic [2:0]                       req_type,
    input  wire logic [1:0]                       color,
    input  wire logic [tls_pkg::PERIOD_W-1:0]     glow_time,
    input  wire logic                             blink_enable,

    // results
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output logic                                  red_on,
    output logic                                  yellow_on,
    output logic                                  green_on,
    output logic [1:0]                            mode
);
    import tls_pkg::*;

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    result_t     step_res;
    logic        push;
    logic        pop;

    // two-entry result queue, entry 0 is the head
    result_t     q0_reg;
    result_t     q1_reg;
    logic [1:0]  count_reg;

    // ---------------------------------------------------------------- registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cycle_period     <= PERIOD_RESET;
            cfg_reg.blink_on_period  <= PERIOD_RESET;
            cfg_reg.blink_off_period <= PERIOD_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_CYCLE:     cfg_reg.cycle_period     <= pwdata[PERIOD_W-1:0];
                REG_BLINK_ON:  cfg_reg.blink_on_period  <= pwdata[PERIOD_W-1:0];
                REG_BLINK_OFF: cfg_reg.blink_off_period <= pwdata[PERIOD_W-1:0];
                default:       ;
            endcase
        end
    end

    // read back, unused slot reads zero
    always_comb
    begin
        case (reg_idx)
            REG_CYCLE:     prdata = APB_DATA_W'(cfg_reg.cycle_period);
            REG_BLINK_ON:  prdata = APB_DATA_W'(cfg_reg.blink_on_period);
            REG_BLINK_OFF: prdata = APB_DATA_W'(cfg_reg.blink_off_period);
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- controller
    assign item_ready = (count_reg != 2'd2);
    assign push       = item_valid && item_ready;
    assign pop        = result_valid && result_ready;

    tls_ctrl #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .step_en      (push),
        .req_type     (req_type),
        .color        (color),
        .glow_time    (glow_time),
        .blink_enable (blink_enable),
        .res          (step_res)
    );

    // ---------------------------------------------------------------- result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else if (push && !pop)
            count_reg <= count_reg + 2'd1;
        else if (pop && !push)
            count_reg <= count_reg - 2'd1;
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (push && pop)
        begin
            if (count_reg == 2'd1)
                q0_reg <= step_res;
            else
            begin
                q0_reg <= q1_reg;
                q1_reg <= step_res;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                q0_reg <= step_res;
            else
                q1_reg <= step_res;
        end
        else if (pop)
        begin
            q0_reg <= q1_reg;
        end
    end

    assign result_valid = (count_reg != 2'd0);
    assign red_on       = q0_reg.red_on;
    assign yellow_on    = q0_reg.yellow_on;
    assign green_on     = q0_reg.green_on;
    assign mode         = q0_reg.mode;

endmodule

`default_nettype wire

// File: tb/tricolor_led_sequencer_tb.sv
// self-checking testbench for the tricolour led sequencer: predictor, scoreboard and drivers
`timescale 1ns / 1ps

module tricolor_led_sequencer_tb;

    import tls_pkg::*;

    // undefined request type, counts as neither event nor tick
    localparam logic [2:0]  EV_UNDEFINED   = 3'd7;
    localparam logic [15:0] TIMER_MAX      = 16'hFFFF;
    localparam logic [15:0] PERIOD_MAX     = 16'hFFFF;
    localparam int unsigned MAX_GAP        = 18;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned SETTINGS_RUN   = 8;
    localparam int unsigned ITEMS_PER_SET  = 190;

    // light predictor and store of expected light levels
    class led_scoreboard;
        logic [15:0] cycle_period;
        logic [15:0] blink_on_period;
        logic [15:0] blink_off_period;
        logic [1:0]  ctrl_mode;
        logic [1:0]  cycle_pos;
        logic [15:0] main_timer;
        logic [15:0] blink_timer;
        logic        lit_phase;
        logic [1:0]  show_color;
        logic [15:0] show_glow;
        logic        show_blink;
        logic [2:0]  leds;
        result_t     expected_lights[$];
        int unsigned errors;

        function new();
            cycle_period     = PERIOD_RESET;
            blink_on_period  = PERIOD_RESET;
            blink_off_period = PERIOD_RESET;
            ctrl_mode        = MODE_IDLE;
            cycle_pos        = '0;
            main_timer       = '0;
            blink_timer      = '0;
            lit_phase        = 1'b0;
            show_color       = COLOR_RED;
            show_glow        = '0;
            show_blink       = 1'b0;
            leds             = '0;
            errors           = 0;
        endfunction

        function void set_period(logic [1:0] idx, logic [15:0] value);
            case (idx)
                REG_CYCLE:     cycle_period = value;
                REG_BLINK_ON:  blink_on_period = value;
                REG_BLINK_OFF: blink_off_period = value;
                default: ;
            endcase
        endfunction

        function logic [15:0] bump(logic [15:0] t);
            return (t == TIMER_MAX) ? t : t + 16'd1;
        endfunction

        function int unsigned outstanding();
            return expected_lights.size();
        endfunction

        // one controller step for an accepted item transfer
        function void note_item(logic [2:0] ev, logic [1:0] col, logic [15:0] glow, logic blk);
            result_t want;
            logic    expired;
            if (ev == EV_TICK) begin
                main_timer  = bump(main_timer);
                blink_timer = bump(blink_timer);
            end
            case (ctrl_mode)
                MODE_STARTUP: begin
                    if (ev == EV_DONE) begin
                        ctrl_mode = MODE_IDLE;
                        leds      = '0;
                    end
                    else if (main_timer >= cycle_period) begin
                        cycle_pos  = (cycle_pos >= 2'd3) ? 2'd1 : cycle_pos + 2'd1;
                        leds       = 3'b001 << (cycle_pos - 2'd1);
                        main_timer = '0;
                    end
                end
                MODE_IDLE: begin
                    if (ev == EV_RUN) begin
                        ctrl_mode  = MODE_STARTUP;
                        main_timer = '0;
                    end
                    else if (ev == EV_SHOW) begin
                        show_color  = col;
                        show_glow   = glow;
                        show_blink  = blk;
                        lit_phase   = 1'b1;
                        ctrl_mode   = MODE_SHOW;
                        main_timer  = '0;
                        blink_timer = '0;
                    end
                end
                MODE_SHOW: begin
                    expired = (show_glow != GLOW_FOREVER) && (main_timer >= show_glow);
                    if (expired || ev == EV_OFF) begin
                        leds      = '0;
                        ctrl_mode = MODE_IDLE;
                    end
                    else if (lit_phase) begin
                        if (show_color != COLOR_NONE)
                            leds = 3'b001 << show_color;
                        if (show_blink && blink_timer >= blink_on_period) begin
                            lit_phase   = 1'b0;
                            blink_timer = '0;
                        end
                    end
                    else begin
                        leds = '0;
                        if (show_blink && blink_timer >= blink_off_period) begin
                            lit_phase   = 1'b1;
                            blink_timer = '0;
                        end
                    end
                end
                default: ctrl_mode = MODE_IDLE;
            endcase
            want.red_on    = leds[0];
            want.yellow_on = leds[1];
            want.green_on  = leds[2];
            want.mode      = ctrl_mode;
            expected_lights.push_back(want);
        endfunction

        function void compare_field(string name, logic [1:0] want, logic [1:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic red, logic yellow, logic green, logic [1:0] md);
            result_t want;
            if (expected_lights.size() == 0) begin
                $display("%0t: result with nothing expected, actual r%0b y%0b g%0b mode %0d",
                         $time, red, yellow, green, md);
                errors++;
                return;
            end
            want = expected_lights.pop_front();
            compare_field("red_on", want.red_on, red);
            compare_field("yellow_on", want.yellow_on, yellow);
            compare_field("green_on", want.green_on, green);
            compare_field("mode", want.mode, md);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  item_valid;
    logic                  item_ready;
    logic [2:0]            req_type;
    logic [1:0]            color;
    logic [PERIOD_W-1:0]   glow_time;
    logic                  blink_enable;
    logic                  result_valid;
    logic                  result_ready;
    logic                  red_on;
    logic                  yellow_on;
    logic                  green_on;
    logic [1:0]            mode;

    led_scoreboard sb;
    int unsigned   items_sent;
    int unsigned   quiet_cycles;
    bit            feed_burst;
    bit            take_burst;
    bit            hold_request;

    tricolor_led_sequencer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .req_type     (req_type),
        .color        (color),
        .glow_time    (glow_time),
        .blink_enable (blink_enable),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .red_on       (red_on),
        .yellow_on    (yellow_on),
        .green_on     (green_on),
        .mode         (mode)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // idle cycles before the next transfer; a side now and then flips into a
    // stretch with no idling at all
    function automatic int unsigned next_gap(ref bit burst);
        if ($urandom_range(0, 31) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [15:0] pick_period();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return PERIOD_MAX;
            default: return 16'($urandom_range(1, 12));
        endcase
    endfunction

    // offer one item and hold it until the transfer; valid stays high on return
    // so that a follow-up item with no gap is not lowered and raised in one step
    task automatic send_item(logic [2:0] ev, logic [1:0] col, logic [15:0] glow, logic blk);
        int unsigned gap;
        gap = next_gap(feed_burst);
        if (gap != 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid   <= 1'b1;
        req_type     <= ev;
        color        <= col;
        glow_time    <= glow;
        blink_enable <= blk;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        items_sent++;
    endtask

    // event whose other fields are ignored, so they carry random bits
    task automatic send_event(logic [2:0] ev);
        send_item(ev, 2'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // anything at all, undefined types included
    task automatic stray_item();
        send_item(3'($urandom), 2'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic tick_run(int unsigned ticks);
        repeat (ticks)
        begin
            if ($urandom_range(0, 9) == 0)
                stray_item();
            else
                send_event(EV_TICK);
        end
    endtask

    // stop offering and wait until every expected result has been taken
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    // write all three periods back to back, psel held across the writes
    task automatic set_periods(logic [15:0] cyc, logic [15:0] on_len, logic [15:0] off_len);
        logic [15:0] vals [3];
        logic [1:0]  regs [3];
        vals = '{cyc, on_len, off_len};
        regs = '{REG_CYCLE, REG_BLINK_ON, REG_BLINK_OFF};
        for (int i = 0; i < 3; i++)
        begin
            psel    <= 1'b1;
            pwrite  <= 1'b1;
            penable <= 1'b0;
            paddr   <= {regs[i], 2'b00};
            pwdata  <= {16'($urandom), vals[i]};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            sb.set_period(regs[i], vals[i]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // well-formed startup cycling with random length, mostly closed by a complete event
    task automatic startup_episode();
        send_event(EV_RUN);
        tick_run($urandom_range(0, 40));
        if ($urandom_range(0, 9) != 0)
            send_event(EV_DONE);
    endtask

    // well-formed show with random colour, glow time and blink, mostly ended by turn-off
    task automatic show_episode();
        logic [15:0] glow;
        case ($urandom_range(0, 9))
            0:       glow = GLOW_FOREVER;
            1:       glow = 16'($urandom);
            2:       glow = '0;
            default: glow = 16'($urandom_range(1, 30));
        endcase
        send_item(EV_SHOW, 2'($urandom), glow, $urandom_range(0, 3) != 0);
        tick_run($urandom_range(0, 40));
        if (glow == GLOW_FOREVER || $urandom_range(0, 4) != 0)
            send_event(EV_OFF);
    endtask

    // every item transfer feeds the predictor, every result transfer is checked
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (item_valid && item_ready)
                sb.note_item(req_type, color, glow_time, blink_enable);
            if (result_valid && result_ready)
                sb.check_result(red_on, yellow_on, green_on, mode);
        end
    end

    // watchdog: too long without any transfer on any port ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
            || (psel && penable && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tricolor_led_sequencer regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: random readiness, plus one long hold-off on request so the
    // result queue fills and the item side stalls
    initial
    begin
        int unsigned gap;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request) begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end
            else
                gap = next_gap(take_burst);
            if (gap != 0) begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    initial
    begin
        int unsigned stop_at;
        sb           = new();
        items_sent   = 0;
        hold_request = 1'b0;
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        item_valid   <= 1'b0;
        req_type     <= EV_TICK;
        color        <= COLOR_RED;
        glow_time    <= '0;
        blink_enable <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset periods: a blinking show stays lit for a long time
        send_item(EV_TICK, COLOR_NONE, GLOW_FOREVER, 1'b1);
        send_item(EV_SHOW, COLOR_RED, GLOW_FOREVER, 1'b1);
        send_item(EV_TICK, COLOR_RED, '0, 1'b0);
        send_item(EV_OFF, COLOR_YELLOW, 16'h5A5A, 1'b0);
        drain_results();

        // short cycle period and blink on, zero blink off period
        set_periods(16'd1, 16'd1, '0);
        send_event(EV_UNDEFINED);
        // events ignored while idle
        send_event(EV_DONE);
        send_event(EV_OFF);
        // red, yellow, green, then back to red
        send_event(EV_RUN);
        repeat (4) send_event(EV_TICK);
        // show request is dropped during startup
        send_item(EV_SHOW, COLOR_GREEN, 16'd5, 1'b1);
        send_event(EV_DONE);
        // colour none, no timeout, blinking
        send_item(EV_SHOW, COLOR_NONE, GLOW_FOREVER, 1'b1);
        repeat (3) send_event(EV_TICK);
        send_event(EV_OFF);
        // zero glow time expires at the next step, which drops the run
        send_item(EV_SHOW, COLOR_GREEN, '0, 1'b0);
        send_event(EV_RUN);
        // cycle position carried over from the earlier run
        send_event(EV_RUN);
        send_event(EV_TICK);
        send_event(EV_DONE);

        // random part, one period setting at a time, extremes first
        for (int setting = 0; setting < SETTINGS_RUN; setting++)
        begin
            drain_results();
            if (setting == 0)
                set_periods('0, '0, '0);
            else if (setting == 1)
                set_periods(PERIOD_MAX, PERIOD_MAX, PERIOD_MAX);
            else
                set_periods(pick_period(), pick_period(), pick_period());
            if (setting == 3) begin
                hold_request = 1'b1;
                feed_burst   = 1'b1;
            end
            stop_at = items_sent + ITEMS_PER_SET;
            while (items_sent < stop_at)
            begin
                case ($urandom_range(0, 9))
                    0, 1:       repeat ($urandom_range(1, 6)) stray_item();
                    2, 3, 4, 5: startup_episode();
                    default:    show_episode();
                endcase
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tricolor_led_sequencer regression: pass");
        else
            $display("tricolor_led_sequencer regression: fail");
        $finish;
    end

endmodule
